>>> hdl/kdlp_pkg.sv
// kdlp_pkg: shared constants, register codes and structs for the key debouncer
// no dependencies; compiled before the interfaces and all modules
package kdlp_pkg;

   localparam int NUM_KEYS_DEFAULT    = 3;
   localparam int COUNT_WIDTH_DEFAULT = 16;

   // control register geometry
   localparam int CFG_WIDTH      = 16;
   localparam int CSR_ADDR_WIDTH = 2;

   localparam logic [CFG_WIDTH-1:0] DEBOUNCE_RESET   = 16'd5;
   localparam logic [CFG_WIDTH-1:0] LONG_PRESS_RESET = 16'd100;

   typedef enum logic [CSR_ADDR_WIDTH-1:0] {
      CSR_DEBOUNCE_TICKS   = 2'd0,
      CSR_LONG_PRESS_TICKS = 2'd1
   } csr_index_type;

   typedef struct packed {
      logic [CFG_WIDTH-1:0] debounce_ticks;
      logic [CFG_WIDTH-1:0] long_press_ticks;
   } thresholds_type;

   typedef struct packed {
      logic press_event;
      logic long_press_event;
      logic release_event;
      logic down;
      logic long_held;
   } key_result_type;

endpackage

>>> hdl/kdlp_if.sv
// kdlp_if: valid/ready channel interfaces for ticks, results and register writes
// depends on kdlp_pkg for the default key count and the register word and index widths
interface kdlp_req_if #(
   parameter int NUM_KEYS = kdlp_pkg::NUM_KEYS_DEFAULT
);
   logic                valid;
   logic                ready;
   logic [NUM_KEYS-1:0] raw_keys;

   modport source (output valid, output raw_keys, input ready);
   modport sink   (input valid, input raw_keys, output ready);
endinterface

interface kdlp_rsp_if #(
   parameter int NUM_KEYS = kdlp_pkg::NUM_KEYS_DEFAULT
);
   logic                  valid;
   logic                  ready;
   logic [NUM_KEYS-1:0]   press_events;
   logic [NUM_KEYS-1:0]   long_press_events;
   logic [NUM_KEYS-1:0]   release_events;
   logic [2*NUM_KEYS-1:0] key_status;

   modport source (output valid, output press_events, output long_press_events,
                   output release_events, output key_status, input ready);
   modport sink   (input valid, input press_events, input long_press_events,
                   input release_events, input key_status, output ready);
endinterface

interface kdlp_csr_if;
   logic                                valid;
   logic                                ready;
   logic [kdlp_pkg::CSR_ADDR_WIDTH-1:0] index;
   logic [kdlp_pkg::CFG_WIDTH-1:0]      data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

>>> hdl/kdlp_csr.sv
// kdlp_csr: debounce and long-press threshold registers
// depends on kdlp_pkg and the kdlp_csr_if interface
module kdlp_csr (
   input  logic                     clock,
   input  logic                     reset,
   kdlp_csr_if.sink                 csr_chan,
   output kdlp_pkg::thresholds_type thresholds
);
   import kdlp_pkg::*;

   logic [CFG_WIDTH-1:0] debounce_ff, debounce_in;
   logic [CFG_WIDTH-1:0] long_press_ff, long_press_in;

   assign csr_chan.ready = 1'b1;

   always_comb begin
      debounce_in   = debounce_ff;
      long_press_in = long_press_ff;
      if (csr_chan.valid) begin
         unique case (csr_chan.index)
            CSR_DEBOUNCE_TICKS:   debounce_in   = csr_chan.data;
            CSR_LONG_PRESS_TICKS: long_press_in = csr_chan.data;
            default: ; // unused indexes are ignored
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         debounce_ff   <= DEBOUNCE_RESET;
         long_press_ff <= LONG_PRESS_RESET;
      end else begin
         debounce_ff   <= debounce_in;
         long_press_ff <= long_press_in;
      end
   end

   assign thresholds.debounce_ticks   = debounce_ff;
   assign thresholds.long_press_ticks = long_press_ff;

endmodule

>>> hdl/kdlp_key.sv
// kdlp_key: per-key hold/idle counters and pressed/long-pressed flags
// depends on kdlp_pkg for the threshold and result structs
module kdlp_key #(
   parameter int COUNT_WIDTH = kdlp_pkg::COUNT_WIDTH_DEFAULT
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     enable,
   input  logic                     level,
   input  kdlp_pkg::thresholds_type thresholds,
   output kdlp_pkg::key_result_type result
);
   import kdlp_pkg::*;

   localparam int CMP_WIDTH = (COUNT_WIDTH > CFG_WIDTH) ? COUNT_WIDTH : CFG_WIDTH;

   logic [COUNT_WIDTH-1:0] hold_ff, hold_in;
   logic [COUNT_WIDTH-1:0] idle_ff, idle_in;
   logic                   down_ff, down_in;
   logic                   long_ff, long_in;

   logic [COUNT_WIDTH-1:0] hold_inc, idle_inc;
   logic [CMP_WIDTH-1:0]   hold_cmp, idle_cmp, debounce_cmp, long_cmp;
   logic                   press_ev, long_ev, release_ev;

   // saturating increments
   assign hold_inc = (hold_ff == '1) ? hold_ff : hold_ff + 1'b1;
   assign idle_inc = (idle_ff == '1) ? idle_ff : idle_ff + 1'b1;

   assign hold_cmp     = CMP_WIDTH'(hold_inc);
   assign idle_cmp     = CMP_WIDTH'(idle_inc);
   assign debounce_cmp = CMP_WIDTH'(thresholds.debounce_ticks);
   assign long_cmp     = CMP_WIDTH'(thresholds.long_press_ticks);

   always_comb begin
      hold_in    = hold_ff;
      idle_in    = idle_ff;
      down_in    = down_ff;
      long_in    = long_ff;
      press_ev   = 1'b0;
      long_ev    = 1'b0;
      release_ev = 1'b0;
      if (level) begin
         idle_in = '0;
         hold_in = hold_inc;
         if (hold_cmp > debounce_cmp) begin
            if (!down_ff) begin
               down_in  = 1'b1;
               press_ev = 1'b1;
            end
            if (hold_cmp > long_cmp && !long_ff) begin
               long_in = 1'b1;
               long_ev = 1'b1;
            end
         end
      end else begin
         hold_in = '0;
         if (down_ff) begin
            idle_in = idle_inc;
            if (idle_cmp > debounce_cmp) begin
               down_in    = 1'b0;
               long_in    = 1'b0;
               release_ev = !long_ff;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_ff <= '0;
         idle_ff <= '0;
         down_ff <= 1'b0;
         long_ff <= 1'b0;
      end else if (enable) begin
         hold_ff <= hold_in;
         idle_ff <= idle_in;
         down_ff <= down_in;
         long_ff <= long_in;
      end
   end

   assign result.press_event      = press_ev;
   assign result.long_press_event = long_ev;
   assign result.release_event    = release_ev;
   assign result.down             = down_in;
   assign result.long_held        = long_in;

endmodule

>>> hdl/key_debounce_long_press.sv
// key debouncer with long-press detection, one timer tick per input word
// path: a tick accepted into the tick register moves on to the result register, where the result word is valid
// throughput: one tick per cycle while the result register is free or being taken, set by the per-key counter update
// req ready stays high while the result register drains or is free
// reset (synchronous): clears counters, flags and both stage valids; thresholds to 5 and 100
module key_debounce_long_press #(
   parameter int NUM_KEYS    = kdlp_pkg::NUM_KEYS_DEFAULT,
   parameter int COUNT_WIDTH = kdlp_pkg::COUNT_WIDTH_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   kdlp_req_if.sink   req_chan,
   kdlp_rsp_if.source rsp_chan,
   kdlp_csr_if.sink   csr_chan
);
   import kdlp_pkg::*;

   // tick register
   logic                  in_valid_ff, in_valid_in;
   logic [NUM_KEYS-1:0]   raw_ff;

   // result register
   logic                  out_valid_ff, out_valid_in;
   logic [NUM_KEYS-1:0]   press_ff, long_press_ff, release_ff;
   logic [2*NUM_KEYS-1:0] status_ff;

   logic                  advance;
   logic                  req_take;
   thresholds_type        thresholds;
   key_result_type        key_res [NUM_KEYS];

   logic [NUM_KEYS-1:0]   press_vec, long_vec, release_vec, down_vec, long_held_vec;

   // tick moves to the result register when that is empty or being taken
   assign advance  = in_valid_ff && (!out_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !in_valid_ff || advance;
   assign req_take = req_chan.valid && req_chan.ready;

   kdlp_csr u_csr (
      .clock      (clock),
      .reset      (reset),
      .csr_chan   (csr_chan),
      .thresholds (thresholds)
   );

   // one cell per key; raw bits are in reverse key order
   for (genvar k = 0; k < NUM_KEYS; k++) begin : g_key
      kdlp_key #(
         .COUNT_WIDTH (COUNT_WIDTH)
      ) u_key (
         .clock      (clock),
         .reset      (reset),
         .enable     (advance),
         .level      (raw_ff[NUM_KEYS-1-k]),
         .thresholds (thresholds),
         .result     (key_res[k])
      );

      assign press_vec[k]     = key_res[k].press_event;
      assign long_vec[k]      = key_res[k].long_press_event;
      assign release_vec[k]   = key_res[k].release_event;
      assign down_vec[k]      = key_res[k].down;
      assign long_held_vec[k] = key_res[k].long_held;
   end

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_take) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      if (advance) begin
         out_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         out_valid_in = 1'b0;
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // payload registers, no reset
   always_ff @(posedge clock) begin
      if (req_take) begin
         raw_ff <= req_chan.raw_keys;
      end
      if (advance) begin
         press_ff      <= press_vec;
         long_press_ff <= long_vec;
         release_ff    <= release_vec;
         status_ff     <= {long_held_vec, down_vec};
      end
   end

   assign rsp_chan.valid             = out_valid_ff;
   assign rsp_chan.press_events      = press_ff;
   assign rsp_chan.long_press_events = long_press_ff;
   assign rsp_chan.release_events    = release_ff;
   assign rsp_chan.key_status        = status_ff;

`ifndef NO_ASSERTIONS
   // a key cannot be pressed and released in the same tick
   assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |-> ((press_ff & release_ff) == '0))
      else $error("press and release on the same key in one word");

   // a long-pressed key is always also pressed
   assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |-> ((status_ff[2*NUM_KEYS-1:NUM_KEYS] & ~status_ff[NUM_KEYS-1:0]) == '0))
      else $error("long-pressed flag without pressed flag");

   // a long-press event leaves the long-pressed flag set
   assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |-> ((long_press_ff & ~status_ff[2*NUM_KEYS-1:NUM_KEYS]) == '0))
      else $error("long-press event with long-pressed flag clear");

   // a tick moving on always fills the result register
   assert property (@(posedge clock) disable iff (reset)
      advance |=> out_valid_ff)
      else $error("result word lost after advance");
`endif

endmodule
